>>> rtl/core/key_value_table_with_holes_assert.svh
// ----------------------------------------------------------------------------
// Key/value table assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_WITH_HOLES_ASSERT_SVH
`define KEY_VALUE_TABLE_WITH_HOLES_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define KVT_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("key/value table check failed");

// Check that a condition implies another in the next cycle
`define KVT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("key/value table sequencing check failed");

`endif

>>> rtl/core/kvt_pkg.sv
// ----------------------------------------------------------------------------
// Key/value table package
// Shared defaults, command and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Default sizes
  localparam int DEPTH_DEF       = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Command codes on the cmd port (the fourth code is a no-op)
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Table update chosen by the controller
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_APPEND    = 3'd1,
    OP_LAST_HOLE = 3'd2,
    OP_SCAN_HOLE = 3'd3,
    OP_GET       = 3'd4,
    OP_REMOVE    = 3'd5
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    compare;
    logic    pick;
    logic    commit;
    op_t     op;
    status_t status;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;
    logic       hole_found;
    logic       holes_zero;
    logic       table_full;
    logic       last_valid;
  } dp_stat_t;

endpackage

>>> rtl/core/kvt_datapath.sv
// ----------------------------------------------------------------------------
// Key/value table datapath
// Holds the command word, the key array with one comparator per slot, the
// value memory, the occupancy bits and the hole bookkeeping.
// ----------------------------------------------------------------------------
module kvt_datapath #(
  parameter int DEPTH       = kvt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF,
  parameter int IDX_W       = $clog2(DEPTH),
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kvt_pkg::ctrl_cmd_t     ctrl,
  output kvt_pkg::dp_stat_t      stat,
  input  logic [1:0]             cmd,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic [1:0]             status,
  output logic [VALUE_WIDTH-1:0] found_value,
  output logic [IDX_W-1:0]       slot,
  output logic [CNT_W-1:0]       entry_count
);
  import kvt_pkg::*;

  // Latched command word
  logic [1:0]             cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;

  // Table storage and bookkeeping
  logic [KEY_WIDTH-1:0]   key_store [DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
  logic [DEPTH-1:0]       occupied;
  logic [CNT_W-1:0]       used_length;
  logic [CNT_W-1:0]       hole_count;
  logic [IDX_W-1:0]       last_hole;
  logic                   last_valid;
  logic [CNT_W-1:0]       live_count;

  // Compare and pick stages
  logic [DEPTH-1:0] match_vec;
  logic [DEPTH-1:0] free_vec;
  logic [DEPTH-1:0] match_low;
  logic [DEPTH-1:0] free_low;
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx;
  logic             hole_q;
  logic [IDX_W-1:0] hole_idx;

  // Result registers
  logic [1:0]             status_q;
  logic [VALUE_WIDTH-1:0] found_q;
  logic [IDX_W-1:0]       slot_q;

  logic [IDX_W-1:0] target;
  logic             is_put;

  // Encode a one-hot vector as its bit index
  function automatic logic [IDX_W-1:0] onehot_index(input logic [DEPTH-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q   <= cmd;
      key_q   <= key;
      value_q <= value;
    end
  end

  // Compare the key against every slot and mark holes below the used length
  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      for (int i = 0; i < DEPTH; i++) begin
        match_vec[i] <= occupied[i] && (key_store[i] == key_q);
        free_vec[i]  <= !occupied[i] && (CNT_W'(i) < used_length);
      end
    end
  end

  // Isolate the lowest set bit of each vector
  assign match_low = match_vec & (~match_vec + DEPTH'(1));
  assign free_low  = free_vec & (~free_vec + DEPTH'(1));

  // Register the lowest matching slot and the lowest hole
  always_ff @(posedge clk) begin
    if (ctrl.pick) begin
      hit_q    <= |match_vec;
      hit_idx  <= onehot_index(match_low);
      hole_q   <= |free_vec;
      hole_idx <= onehot_index(free_low);
    end
  end

  // Select the slot a put fills, or the matching slot otherwise
  always_comb begin
    case (ctrl.op)
      OP_APPEND:    target = used_length[IDX_W-1:0];
      OP_LAST_HOLE: target = last_hole;
      OP_SCAN_HOLE: target = hole_idx;
      default:      target = hit_idx;
    endcase
  end

  assign is_put = ctrl.commit &&
                  (ctrl.op == OP_APPEND || ctrl.op == OP_LAST_HOLE ||
                   ctrl.op == OP_SCAN_HOLE);

  // Write key and value stores on a put
  always_ff @(posedge clk) begin
    if (is_put) begin
      key_store[target] <= key_q;
      value_mem[target] <= value_q;
    end
  end

  // Read the value memory on a successful get, else drive zero
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      if (ctrl.op == OP_GET) begin
        found_q <= value_mem[hit_idx];
      end else begin
        found_q <= '0;
      end
    end
  end

  // Update occupancy and hole bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied    <= '0;
      used_length <= '0;
      hole_count  <= '0;
      last_hole   <= '0;
      last_valid  <= 1'b0;
      live_count  <= '0;
    end else if (ctrl.commit) begin
      case (ctrl.op)
        OP_APPEND: begin
          occupied[target] <= 1'b1;
          used_length      <= used_length + CNT_W'(1);
          live_count       <= live_count + CNT_W'(1);
        end
        OP_LAST_HOLE: begin
          occupied[target] <= 1'b1;
          last_valid       <= 1'b0;
          hole_count       <= hole_count - CNT_W'(1);
          live_count       <= live_count + CNT_W'(1);
        end
        OP_SCAN_HOLE: begin
          occupied[target] <= 1'b1;
          hole_count       <= hole_count - CNT_W'(1);
          live_count       <= live_count + CNT_W'(1);
        end
        OP_REMOVE: begin
          occupied[hit_idx] <= 1'b0;
          hole_count        <= hole_count + CNT_W'(1);
          live_count        <= live_count - CNT_W'(1);
          last_hole         <= hit_idx;
          last_valid        <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Register status and slot for the result word
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      status_q <= ctrl.status;
      slot_q   <= (ctrl.op == OP_NONE) ? '0 : target;
    end
  end

  // Report to the controller
  assign stat.cmd        = cmd_q;
  assign stat.hit        = hit_q;
  assign stat.hole_found = hole_q;
  assign stat.holes_zero = (hole_count == '0);
  assign stat.table_full = (used_length == CNT_W'(DEPTH));
  assign stat.last_valid = last_valid;

  assign status      = status_q;
  assign found_value = found_q;
  assign slot        = slot_q;
  assign entry_count = live_count;

endmodule

>>> rtl/core/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// Key/value table controller
// Steps each command through compare, pick and decide, chooses the table
// update and the status, and strobes the result word.
// ----------------------------------------------------------------------------
module kvt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  kvt_pkg::dp_stat_t  stat,
  output kvt_pkg::ctrl_cmd_t ctrl
);
  import kvt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CMP    = 4'b0010,
    S_PICK   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DECIDE);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_CMP;
      S_CMP:    state_next = S_PICK;
      S_PICK:   state_next = S_DECIDE;
      S_DECIDE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // Choose the update and status from the lookup results
  always_comb begin
    ctrl.load    = (state == S_IDLE) && start;
    ctrl.compare = (state == S_CMP);
    ctrl.pick    = (state == S_PICK);
    ctrl.commit  = (state == S_DECIDE);
    ctrl.op      = OP_NONE;
    ctrl.status  = ST_OK;
    unique case (stat.cmd)
      CMD_PUT: begin
        if (stat.hit) begin
          ctrl.status = ST_PRESENT;
        end else if (stat.holes_zero) begin
          if (stat.table_full) begin
            ctrl.status = ST_FULL;
          end else begin
            ctrl.op = OP_APPEND;
          end
        end else if (stat.last_valid) begin
          ctrl.op = OP_LAST_HOLE;
        end else if (stat.hole_found) begin
          ctrl.op = OP_SCAN_HOLE;
        end else begin
          ctrl.status = ST_FULL;
        end
      end
      CMD_GET: begin
        if (stat.hit) begin
          ctrl.op = OP_GET;
        end else begin
          ctrl.status = ST_ABSENT;
        end
      end
      CMD_REMOVE: begin
        if (stat.hit) begin
          ctrl.op = OP_REMOVE;
        end else begin
          ctrl.status = ST_ABSENT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/key_value_table_with_holes.sv
// ----------------------------------------------------------------------------
// Key/value table with holes
// Fixed-depth table of key/value slots taking put, get and remove commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive cmd, key and value and raise start; the word is
//   taken at a clock edge where start is high and busy is low.
//   Output channel: done is high for exactly one cycle with status,
//   found_value, slot and entry_count; the receiver cannot stall, so the
//   result must be captured in that cycle.
// Sequence: after the accepting edge the controller steps through compare, pick
//   and decide (compare all slots, pick lowest match and hole, update), then done rises.
// The block stays busy until a command finishes, so commands do not overlap;
//   a new word is taken in the cycle that done is high.
// Lookup compares the key against every slot in parallel and takes the
//   lowest occupied match; the value store is a memory with a registered
//   read port.
// Reset: synchronous on rst; clears occupancy, counts and hole tracking.
//   Key and value stores keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module key_value_table_with_holes #(
  parameter int DEPTH       = kvt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF,
  parameter int IDX_W       = $clog2(DEPTH),
  parameter int CNT_W       = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             cmd,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   done,
  output logic [1:0]             status,
  output logic [VALUE_WIDTH-1:0] found_value,
  output logic [IDX_W-1:0]       slot,
  output logic [CNT_W-1:0]       entry_count
);
  import kvt_pkg::*;

`include "key_value_table_with_holes_assert.svh"

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  kvt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  kvt_datapath #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .cmd         (cmd),
    .key         (key),
    .value       (value),
    .status      (status),
    .found_value (found_value),
    .slot        (slot),
    .entry_count (entry_count)
  );

  // An accepted word keeps the block busy and yields no result next cycle
  `KVT_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  // Result strobes never come back to back
  `KVT_ASSERT_NEXT(a_single_strobe, clk, rst, done, !done)
  // Live entries never exceed the table depth
  `KVT_ASSERT_SAME(a_count_range, clk, rst, done, entry_count <= CNT_W'(DEPTH))
  // A failed command reports slot and value as zero
  `KVT_ASSERT_SAME(a_fail_zero, clk, rst, done && status != ST_OK, slot == '0 && found_value == '0)

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key/value table with holes testbench
// Drives put, get, remove and unused commands into the table and checks
// every result word against an in-bench model of the slots, the hole
// tracking and the entry count. A short directed list covers the corner
// cases; random runs then fill, drain and churn the table.
// ----------------------------------------------------------------------------
module tb;
  import kvt_pkg::*;

  localparam int SLOTS = DEPTH_DEF;
  localparam int WORD_TARGET = 1550;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    bit          drain;
  } table_op_t;

  typedef struct {
    status_t     status;
    logic [31:0] found;
    logic [5:0]  slot;
    logic [6:0]  count;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  cmd = CMD_NOP;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [5:0]  slot;
  logic [6:0]  entry_count;

  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  logic [31:0]   known_keys[$];
  int            n_queued = 0;
  int            n_taken = 0;
  int            n_checked = 0;
  int            n_fail = 0;
  int            stall_cycles = 0;

  // Model of the table contents and hole tracking
  bit [31:0] slot_key[SLOTS];
  bit [31:0] slot_val[SLOTS];
  bit        slot_live[SLOTS];
  int        used_len = 0;
  int        hole_total = 0;
  int        last_free = 0;
  bit        last_free_ok = 1'b0;
  int        live_total = 0;

  key_value_table_with_holes dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .key(key),
    .value(value),
    .done(done),
    .status(status),
    .found_value(found_value),
    .slot(slot),
    .entry_count(entry_count)
  );

  always #2 clk = ~clk;

  // Lowest live slot holding the key, or -1
  function automatic int find_live_key(input logic [31:0] k);
    for (int i = 0; i < used_len; i++) begin
      if (slot_live[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Apply one command to the model and return the word it should produce
  function automatic table_result_t apply_table_op(input table_op_t op);
    table_result_t r;
    int hit;
    int target;
    r.status = ST_OK;
    r.found = '0;
    r.slot = '0;
    target = -1;
    hit = find_live_key(op.key);
    case (op.cmd)
      CMD_PUT: begin
        if (hit >= 0) begin
          r.status = ST_PRESENT;
        end else begin
          if (hole_total == 0) begin
            if (used_len < SLOTS) begin
              target = used_len;
              used_len++;
            end
          end else if (last_free_ok) begin
            target = last_free;
            last_free_ok = 1'b0;
            hole_total--;
          end else begin
            for (int i = 0; i < used_len; i++) begin
              if (!slot_live[i]) begin
                target = i;
                break;
              end
            end
            if (target >= 0) hole_total--;
          end
          if (target < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_key[target] = op.key;
            slot_val[target] = op.value;
            slot_live[target] = 1'b1;
            live_total++;
            r.slot = target[5:0];
          end
        end
      end
      CMD_GET: begin
        if (hit < 0) begin
          r.status = ST_ABSENT;
        end else begin
          r.found = slot_val[hit];
          r.slot = hit[5:0];
        end
      end
      CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_ABSENT;
        end else begin
          slot_live[hit] = 1'b0;
          live_total--;
          hole_total++;
          last_free = hit;
          last_free_ok = 1'b1;
          r.slot = hit[5:0];
        end
      end
      default: begin
      end
    endcase
    r.count = live_total[6:0];
    return r;
  endfunction

  // Queue one command; a few of them wait for the table to go quiet first
  function automatic void add_op(input logic [1:0] c, input logic [31:0] k,
                                 input logic [31:0] v);
    table_op_t op;
    op.cmd = c;
    op.key = k;
    op.value = v;
    op.drain = (n_queued % 500 == 250);
    pending_ops.push_back(op);
    n_queued++;
  endfunction

  // Pick a key that was put earlier, or a random one if none is known
  function automatic logic [31:0] pick_known_key();
    if (known_keys.size() == 0) return $urandom();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Put a fresh key and remember it
  function automatic void add_fresh_put();
    logic [31:0] k;
    k = $urandom();
    known_keys.push_back(k);
    if (known_keys.size() > 200) void'(known_keys.pop_front());
    add_op(CMD_PUT, k, $urandom());
  endfunction

  // Remove a known key and forget it, or a random key if none is known
  function automatic void add_known_remove();
    int idx;
    if (known_keys.size() == 0) begin
      add_op(CMD_REMOVE, $urandom(), $urandom());
      return;
    end
    idx = $urandom_range(0, known_keys.size() - 1);
    add_op(CMD_REMOVE, known_keys[idx], $urandom());
    known_keys.delete(idx);
  endfunction

  // Sender idle rate for the current part of the run
  function automatic int idle_pct();
    if (n_taken < WORD_TARGET / 3) return 38;
    if (n_taken < 2 * WORD_TARGET / 3) return 50;
    return 0;
  endfunction

  // Build the command list, release reset, wait for the last word
  initial begin
    int pick;
    int burst;
    // directed: empty table, extreme keys and values, duplicate put
    add_op(CMD_GET, 32'h0000_0005, 32'h0);
    add_op(CMD_REMOVE, 32'h0000_0005, 32'h0);
    add_op(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    add_op(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    add_op(CMD_PUT, 32'h0000_0000, 32'h0000_0001);
    add_op(CMD_GET, 32'h0000_0000, 32'h0);
    add_op(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(CMD_PUT, 32'h5555_AAAA, 32'hA5A5_A5A5);
    add_op(CMD_PUT, 32'hAAAA_5555, 32'h5A5A_5A5A);
    // refill the most recently freed slot
    add_op(CMD_REMOVE, 32'h0000_0000, 32'h0);
    add_op(CMD_PUT, 32'h1234_5678, 32'hDEAD_BEEF);
    // two holes: the second put has to scan for the lower one
    add_op(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
    add_op(CMD_REMOVE, 32'h5555_AAAA, 32'h0);
    add_op(CMD_PUT, 32'h0000_0011, 32'h1111_1111);
    add_op(CMD_PUT, 32'h0000_0022, 32'h2222_2222);
    add_op(CMD_GET, 32'h0000_0022, 32'h0);
    add_op(CMD_NOP, 32'h0, 32'h0);
    add_op(CMD_REMOVE, 32'h0000_0022, 32'h0);
    add_op(CMD_REMOVE, 32'h0000_0022, 32'h0);
    add_op(CMD_GET, 32'h1234_5678, 32'h0);
    add_op(CMD_GET, 32'hAAAA_5555, 32'h0);

    // random: start by filling the table past full, then mix
    for (int i = 0; i < 70; i++) add_fresh_put();
    while (n_queued < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        for (int i = 0; i < 70; i++) add_fresh_put();
      end else if (pick < 6) begin
        burst = $urandom_range(20, 64);
        for (int i = 0; i < burst; i++) begin
          if ($urandom_range(0, 9) == 0) add_op(CMD_REMOVE, $urandom(), $urandom());
          else add_known_remove();
        end
      end else if (pick < 14) begin
        burst = $urandom_range(2, 4);
        for (int i = 0; i < burst; i++) add_known_remove();
        for (int i = 0; i < burst; i++) add_fresh_put();
      end else if (pick < 40) begin
        if ($urandom_range(0, 9) < 7) add_fresh_put();
        else add_op(CMD_PUT, pick_known_key(), $urandom());
      end else if (pick < 70) begin
        if ($urandom_range(0, 3) != 0) add_op(CMD_GET, pick_known_key(), $urandom());
        else add_op(CMD_GET, $urandom(), $urandom());
      end else if (pick < 92) begin
        if ($urandom_range(0, 9) < 7) add_known_remove();
        else add_op(CMD_REMOVE, $urandom(), $urandom());
      end else begin
        add_op(CMD_NOP, $urandom(), $urandom());
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Driver: hold a word until taken, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_table_op(pending_ops.pop_front()));
        n_taken++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_ops.size() != 0
                   && !(pending_ops[0].drain && expected_results.size() != 0)
                   && $urandom_range(0, 99) >= idle_pct()) begin
        start <= 1'b1;
        cmd   <= pending_ops[0].cmd;
        key   <= pending_ops[0].key;
        value <= pending_ops[0].value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && done) begin
      n_checked++;
      if (expected_results.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result word %0d: status %0d slot %0d",
                                   n_checked, status, slot);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || found_value !== want.found
            || slot !== want.slot || entry_count !== want.count) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("mismatch on word %0d (expected/actual): status %0d/%0d",
                     n_checked, want.status, status);
            $display("  found %h/%h slot %0d/%0d count %0d/%0d", want.found,
                     found_value, want.slot, slot, want.count, entry_count);
          end
        end
      end
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
